FILE: src/u8d_pkg.sv
// Shared types, constants and decode functions for the UTF-8 stream decoder.
package u8d_pkg;

    localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [20:0] MIN_LEN3   = 21'h000800;
    localparam logic [20:0] MIN_LEN4   = 21'h010000;
    localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN2   = 21'h000080;
    localparam logic [1:0]  CONT_TAG   = 2'b10;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One decoded result
    typedef struct packed {
        logic [20:0] code_point;
        logic        is_error;
        logic [2:0]  bytes_used;
        logic        last;
    } result_t;

    // One queue entry: up to two results caused by one input byte
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } entry_t;

    // Outcome of decoding a byte as a lead from the idle state
    typedef struct packed {
        logic        emit;
        result_t     res;
        logic [2:0]  exp_len;
        logic [20:0] acc;
        logic        swallow;
    } lead_t;

    function automatic result_t repl_result(input logic [2:0] used, input logic last);
        result_t r;
        r.code_point = REPL_CHAR;
        r.is_error   = 1'b1;
        r.bytes_used = used;
        r.last       = last;
        return r;
    endfunction

    function automatic lead_t lead_decode(input logic [7:0] b, input logic [2:0] left);
        lead_t      r;
        logic [2:0] ones;
        r = '0;
        priority casez (b)
            8'b0???????: ones = 3'd0;
            8'b10??????: ones = 3'd1;
            8'b110?????: ones = 3'd2;
            8'b1110????: ones = 3'd3;
            8'b11110???: ones = 3'd4;
            default:     ones = 3'd5;
        endcase
        if (ones == 3'd0) begin
            r.emit           = 1'b1;
            r.res.code_point = {13'd0, b};
            r.res.is_error   = 1'b0;
            r.res.bytes_used = 3'd1;
            r.res.last       = 1'b1;
        end else if (ones < 3'd2 || ones > 3'd4) begin
            r.emit = 1'b1;
            r.res  = repl_result(3'd1, 1'b1);
        end else if (ones > left) begin
            if (left <= 3'd1) begin
                r.emit = 1'b1;
                r.res  = repl_result(3'd1, 1'b1);
            end else begin
                r.swallow = 1'b1;
                r.exp_len = left;
            end
        end else begin
            r.exp_len = ones;
            unique case (ones)
                3'd2:    r.acc = {16'd0, b[4:0]};
                3'd3:    r.acc = {17'd0, b[3:0]};
                default: r.acc = {18'd0, b[2:0]};
            endcase
        end
        return r;
    endfunction

    function automatic logic scalar_ok(input logic [2:0] len, input logic [20:0] cp);
        logic ok;
        ok = 1'b1;
        if (len == 3'd2 && cp < MIN_LEN2) ok = 1'b0;
        if (len == 3'd3 && cp < MIN_LEN3) ok = 1'b0;
        if (len == 3'd4 && cp < MIN_LEN4) ok = 1'b0;
        if (cp > MAX_SCALAR) ok = 1'b0;
        if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
        return ok;
    endfunction

endpackage

FILE: src/u8d_front.sv
// Front end: accepts bytes, tracks the pending sequence and builds queue entries.
module u8d_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      data_byte,
    input  logic [2:0]      bytes_left,
    input  logic            q_full,
    output logic            push,
    output u8d_pkg::entry_t push_entry
);
    import u8d_pkg::*;

    logic [2:0]  exp_len_reg, exp_len_next;
    logic [2:0]  rcv_reg, rcv_next;
    logic [20:0] acc_reg, acc_next;
    logic        swallow_reg, swallow_next;

    logic        accept;
    logic [2:0]  left_norm;
    logic [2:0]  rcv_inc;
    logic [20:0] acc_new;
    lead_t       lead;
    entry_t      ent;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Clamp the remaining count into 1..4
    always_comb
    begin
        if (bytes_left == 3'd0)
            left_norm = 3'd1;
        else if (bytes_left > 3'd4)
            left_norm = 3'd4;
        else
            left_norm = bytes_left;
    end

    assign lead    = lead_decode(data_byte, left_norm);
    assign rcv_inc = rcv_reg + 3'd1;
    assign acc_new = {acc_reg[14:0], data_byte[5:0]};

    // Decode the byte against the pending sequence
    always_comb
    begin
        ent          = '0;
        exp_len_next = exp_len_reg;
        rcv_next     = rcv_reg;
        acc_next     = acc_reg;
        swallow_next = swallow_reg;
        if (exp_len_reg == 3'd0) begin
            ent.v0       = lead.emit;
            ent.r0       = lead.res;
            exp_len_next = lead.exp_len;
            rcv_next     = (lead.exp_len != 3'd0) ? 3'd1 : 3'd0;
            acc_next     = lead.acc;
            swallow_next = lead.swallow;
        end else if (swallow_reg) begin
            if (rcv_inc >= exp_len_reg) begin
                ent.v0       = 1'b1;
                ent.r0       = repl_result(exp_len_reg, 1'b1);
                exp_len_next = 3'd0;
                rcv_next     = 3'd0;
                acc_next     = '0;
                swallow_next = 1'b0;
            end else begin
                rcv_next = rcv_inc;
            end
        end else if (data_byte[7:6] != CONT_TAG) begin
            // Broken sequence: flush it, then restart on this byte as a lead
            ent.v0       = 1'b1;
            ent.r0       = repl_result(rcv_reg, !lead.emit);
            ent.v1       = lead.emit;
            ent.r1       = lead.res;
            exp_len_next = lead.exp_len;
            rcv_next     = (lead.exp_len != 3'd0) ? 3'd1 : 3'd0;
            acc_next     = lead.acc;
            swallow_next = lead.swallow;
        end else if (rcv_inc >= exp_len_reg) begin
            ent.v0 = 1'b1;
            if (scalar_ok(exp_len_reg, acc_new)) begin
                ent.r0.code_point = acc_new;
                ent.r0.is_error   = 1'b0;
                ent.r0.bytes_used = exp_len_reg;
                ent.r0.last       = 1'b1;
            end else begin
                ent.r0 = repl_result(exp_len_reg, 1'b1);
            end
            exp_len_next = 3'd0;
            rcv_next     = 3'd0;
            acc_next     = '0;
            swallow_next = 1'b0;
        end else begin
            acc_next = acc_new;
            rcv_next = rcv_inc;
        end
    end

    assign push       = accept && ent.v0;
    assign push_entry = ent;

    // Advance sequence state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            exp_len_reg <= '0;
            rcv_reg     <= '0;
            acc_reg     <= '0;
            swallow_reg <= 1'b0;
        end else if (accept) begin
            exp_len_reg <= exp_len_next;
            rcv_reg     <= rcv_next;
            acc_reg     <= acc_next;
            swallow_reg <= swallow_next;
        end
    end

`ifndef SYNTHESIS
    a_swallow_len: assert property (@(posedge clk) disable iff (!rst_n)
        swallow_reg |-> (exp_len_reg >= 3'd2))
        else $error("swallow active with short length");
    a_rcv_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_len_reg != 3'd0) |-> (rcv_reg < exp_len_reg && rcv_reg != 3'd0))
        else $error("received count out of range for pending sequence");
`endif

endmodule

FILE: src/u8d_fifo.sv
// Short queue of decoded entries between front and back.
module u8d_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u8d_pkg::entry_t push_entry,
    input  logic            pop,
    output u8d_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import u8d_pkg::*;

    entry_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // Move pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

FILE: src/u8d_back.sv
// Back end: unpacks queue entries into one result beat per cycle while the output is not stalled.
module u8d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  u8d_pkg::entry_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output u8d_pkg::result_t out_res
);
    import u8d_pkg::*;

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    hold_valid_reg;
    result_t hold_res_reg;
    logic    load;

    assign load      = !out_valid_reg || out_ready;
    assign pop       = load && !hold_valid_reg && !empty;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Hold the output beat until taken, then refill from hold or queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (load) begin
            if (hold_valid_reg) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else if (!empty) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= head.v0 && head.v1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload path
    always_ff @(posedge clk)
    begin
        if (load) begin
            if (hold_valid_reg) begin
                out_res_reg <= hold_res_reg;
            end else if (!empty) begin
                out_res_reg  <= head.v0 ? head.r0 : head.r1;
                hold_res_reg <= head.r1;
            end
        end
    end

`ifndef SYNTHESIS
    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("second result pending without a first");
    a_hold_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> !pop)
        else $error("queue popped while second result pending");
`endif

endmodule

FILE: src/utf8_stream_decoder_unit.sv
// Top level of the streaming UTF-8 decoder with replacement character output.
//
//  Channel  Dir  tdata (low bit up)                        tuser     tlast
//  s_axis   in   data_byte[7:0], bytes_left[10:8], pad     -         -
//  m_axis   out  code_point[20:0], bytes_used[23:21]       is_error  last
//
// Takes one byte per cycle while the queue is not full. A queue entry is written when
// its byte is accepted, and the output register loads from the queue when it is free,
// so a result beat is offered once it has passed through the queue and output register.
// A byte that causes two results yields two output beats; the
// four-entry queue between front and back absorbs those and output stalls.
// Input ready drops only while the queue is full.
// Reset is asynchronous, active low, and returns the decoder to idle.
module utf8_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], bytes_left[10:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // code_point[20:0], bytes_used[23:21]
    output logic [0:0]  m_axis_tuser,   // is_error[0]
    output logic        m_axis_tlast
);
    import u8d_pkg::*;

    logic    q_push;
    entry_t  q_in;
    logic    q_pop;
    entry_t  q_head;
    logic    q_empty;
    logic    q_full;
    result_t res;

    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata[7:0]),
        .bytes_left (s_axis_tdata[10:8]),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_in)
    );

    u8d_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    u8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result beat
    assign m_axis_tdata = {res.bytes_used, res.code_point};
    assign m_axis_tuser = res.is_error;
    assign m_axis_tlast = res.last;

endmodule

FILE: tb/utf8_decoder_checker.sv
// Checker for the UTF-8 stream decoder: predicts results from input beats and compares.
module utf8_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], bytes_left[10:8]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // code_point[20:0], bytes_used[23:21]
    input  logic [0:0]  m_axis_tuser,   // is_error[0]
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    // Decoder state as the predictor sees it
    logic [2:0]  seq_len;       // length of the open sequence, 0 when idle
    logic [2:0]  seq_seen;      // bytes of the open sequence taken so far
    logic [20:0] seq_bits;      // code point bits gathered so far
    logic        seq_discard;   // dropping the rest of a truncated buffer

    result_t awaited_points[$];
    result_t want;
    int      beat_no;

    task automatic note_mismatch(input string what);
        $display("[%0t] mismatch at result %0d: %s", $time, beat_no, what);
        fail_count++;
    endtask

    function automatic result_t make_point(input logic [20:0] cp, input logic err,
                                           input logic [2:0] used, input logic fin);
        result_t r;
        r.code_point = cp;
        r.is_error   = err;
        r.bytes_used = used;
        r.last       = fin;
        return r;
    endfunction

    // Reject overlong forms, values past the last scalar and surrogates
    function automatic logic scalar_valid(input logic [2:0] len, input logic [20:0] cp);
        logic [20:0] floor_cp;
        case (len)
            3'd2:    floor_cp = MIN_LEN2;
            3'd3:    floor_cp = MIN_LEN3;
            3'd4:    floor_cp = MIN_LEN4;
            default: floor_cp = '0;
        endcase
        return (cp >= floor_cp) && (cp <= MAX_SCALAR) && !(cp >= SURR_LO && cp <= SURR_HI);
    endfunction

    task automatic return_idle();
        seq_len     = '0;
        seq_seen    = '0;
        seq_bits    = '0;
        seq_discard = 1'b0;
    endtask

    // Treat a byte as a lead from idle; emit is set when it yields a result at once
    task automatic open_sequence(input logic [7:0] b, input logic [2:0] left,
                                 output logic emit, output result_t res);
        int ones;
        ones = 0;
        emit = 1'b1;
        res  = make_point(REPL_CHAR, 1'b1, 3'd1, 1'b1);
        while (ones < 5 && b[7 - ones])
            ones++;
        if (ones == 0)
        begin
            res = make_point({13'd0, b}, 1'b0, 3'd1, 1'b1);
        end
        else if (ones >= 2 && ones <= 4)
        begin
            if (ones > left)
            begin
                // truncated tail: swallow what is left, unless this is the last byte
                if (left > 3'd1)
                begin
                    emit        = 1'b0;
                    seq_discard = 1'b1;
                    seq_len     = left;
                    seq_seen    = 3'd1;
                    seq_bits    = '0;
                end
            end
            else
            begin
                emit     = 1'b0;
                seq_len  = 3'(ones);
                seq_seen = 3'd1;
                seq_bits = {13'd0, b & (8'h7F >> ones)};
            end
        end
    endtask

    // Advance the predictor by one input byte and queue the results it causes
    task automatic decode_byte(input logic [7:0] b, input logic [2:0] left_raw);
        logic [2:0] left;
        logic [2:0] used;
        logic [2:0] len;
        logic       emit;
        result_t    res;
        left = (left_raw == 3'd0) ? 3'd1 : (left_raw > 3'd4) ? 3'd4 : left_raw;
        if (seq_len == 3'd0)
        begin
            open_sequence(b, left, emit, res);
            if (emit)
                awaited_points.push_back(res);
        end
        else if (seq_discard)
        begin
            seq_seen++;
            if (seq_seen >= seq_len)
            begin
                awaited_points.push_back(make_point(REPL_CHAR, 1'b1, seq_len, 1'b1));
                return_idle();
            end
        end
        else if (b[7:6] != CONT_TAG)
        begin
            // broken sequence: close it, then decode this byte as a new lead
            used = seq_seen;
            return_idle();
            open_sequence(b, left, emit, res);
            awaited_points.push_back(make_point(REPL_CHAR, 1'b1, used, !emit));
            if (emit)
                awaited_points.push_back(res);
        end
        else
        begin
            seq_bits = {seq_bits[14:0], b[5:0]};
            seq_seen++;
            if (seq_seen >= seq_len)
            begin
                len = seq_len;
                if (scalar_valid(len, seq_bits))
                    awaited_points.push_back(make_point(seq_bits, 1'b0, len, 1'b1));
                else
                    awaited_points.push_back(make_point(REPL_CHAR, 1'b1, len, 1'b1));
                return_idle();
            end
        end
    endtask

    // Predict on each input beat, then check each output beat against the oldest point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            return_idle();
            awaited_points.delete();
            fail_count = 0;
            beat_no    = 0;
            pending   <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata[7:0], s_axis_tdata[10:8]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_points.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected beat cp=%h", m_axis_tdata[20:0]));
                end
                else
                begin
                    want = awaited_points.pop_front();
                    if (m_axis_tdata[20:0] !== want.code_point)
                        note_mismatch($sformatf("code_point %h, want %h",
                                                m_axis_tdata[20:0], want.code_point));
                    if (m_axis_tuser[0] !== want.is_error)
                        note_mismatch($sformatf("is_error %b, want %b",
                                                m_axis_tuser[0], want.is_error));
                    if (m_axis_tdata[23:21] !== want.bytes_used)
                        note_mismatch($sformatf("bytes_used %0d, want %0d",
                                                m_axis_tdata[23:21], want.bytes_used));
                    if (m_axis_tlast !== want.last)
                        note_mismatch($sformatf("last %b, want %b",
                                                m_axis_tlast, want.last));
                end
                beat_no++;
            end
            pending <= awaited_points.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top-level testbench for the UTF-8 stream decoder: stimulus, idling and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // data_byte[7:0], bytes_left[10:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // code_point[20:0], bytes_used[23:21]
    logic [0:0]  m_axis_tuser;   // is_error[0]
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int send_idle;   // percent of cycles the sender holds off
    int recv_idle;   // percent of cycles the receiver stalls
    int bytes_sent;

    utf8_stream_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_decoder_checker check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the output side at random
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one byte, with random hold-off, and wait until it is accepted
    task automatic send_byte(input logic [7:0] b, input logic [2:0] left);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, left, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Hold the sender until every queued result has drained
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Build one buffer of mostly valid sequences and send it with its bytes-left count
    task automatic send_buffer();
        logic [7:0]  text[$];
        logic [20:0] cp;
        logic [20:0] cont;
        logic [2:0]  left;
        int          seq_count;
        int          len;
        int          cuts;
        int          rem;
        seq_count = $urandom_range(1, 8);
        repeat (seq_count)
        begin
            if ($urandom_range(99) < 12)
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       cp = 21'($urandom_range(0, 'h7F));
                    2:       cp = 21'($urandom_range('h80, 'h7FF));
                    3:       cp = 21'($urandom_range('h800, 'hFFFF));
                    default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                endcase
                // mix in overlong forms, surrogates and values past the last scalar
                if (len > 1 && $urandom_range(99) < 10)
                    cp = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
                else if (len == 3 && $urandom_range(99) < 10)
                    cp = 21'($urandom_range('hD800, 'hDFFF));
                else if (len == 4 && $urandom_range(99) < 10)
                    cp = 21'($urandom_range('h110000, 'h1FFFFF));
                cuts = (len > 1 && $urandom_range(99) < 8) ? $urandom_range(1, len - 1) : 0;
                case (len)
                    1:       text.push_back({1'b0, cp[6:0]});
                    2:       text.push_back({3'b110, cp[10:6]});
                    3:       text.push_back({4'b1110, cp[15:12]});
                    default: text.push_back({5'b11110, cp[20:18]});
                endcase
                for (int k = len - 2; k >= cuts; k--)
                begin
                    cont = cp >> (6 * k);
                    text.push_back({2'b10, cont[5:0]});
                end
            end
        end
        // cut the end off some buffers so sequences run past it
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(1, 3))
                if (text.size() > 1)
                    void'(text.pop_back());
        end
        foreach (text[i])
        begin
            rem  = text.size() - i;
            left = (rem > 4) ? 3'd4 : 3'(rem);
            if ($urandom_range(99) < 5)
                left = 3'($urandom_range(0, 7));
            send_byte(text[i], left);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        bytes_sent    = 0;
        send_idle     = 11;
        recv_idle     = 79;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ASCII extremes, with out-of-range bytes-left values
        send_byte(8'h00, 3'd0);
        send_byte(8'h7F, 3'd7);
        // smallest two-byte value and the largest scalar
        send_byte(8'hC2, 3'd4);
        send_byte(8'h80, 3'd1);
        send_byte(8'hF4, 3'd4);
        send_byte(8'h8F, 3'd3);
        send_byte(8'hBF, 3'd2);
        send_byte(8'hBF, 3'd1);
        // surrogate and overlong forms
        send_byte(8'hED, 3'd4);
        send_byte(8'hA0, 3'd4);
        send_byte(8'h80, 3'd4);
        send_byte(8'hC0, 3'd2);
        send_byte(8'h80, 3'd1);
        // lone continuation and a lead with too many ones
        send_byte(8'h80, 3'd4);
        send_byte(8'hFF, 3'd4);
        // truncated tail, then a lead on the last byte of the buffer
        send_byte(8'hE2, 3'd2);
        send_byte(8'h41, 3'd5);
        send_byte(8'hC3, 3'd1);
        // broken sequence ended by an ASCII byte, then by a new lead
        send_byte(8'hE2, 3'd4);
        send_byte(8'h41, 3'd3);
        send_byte(8'hE2, 3'd4);
        send_byte(8'hC3, 3'd4);
        send_byte(8'hA9, 3'd4);
        drain_results();

        // random buffers in three idling phases
        while (bytes_sent < 215)
            send_buffer();
        drain_results();
        send_idle = 79;
        recv_idle = 11;
        while (bytes_sent < 425)
            send_buffer();
        drain_results();
        send_idle = 0;
        recv_idle = 0;
        while (bytes_sent < 640)
            send_buffer();

        // wait out the results still in flight
        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // End a hung run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
